@@ sv/tpde_pkg.sv @@
// Shared types, constants and helpers for the tile pixel draw engine.
// No dependencies; the front end, back end and top level import this package.
package tpde_pkg;

	localparam int MAX_PIXELS    = 4096;
	localparam int PALETTE_WORDS = 256;
	localparam int PIX_AW        = $clog2(MAX_PIXELS);
	localparam int PAL_AW        = 8;
	localparam int TDIM_W        = 10;
	localparam int CLP_W         = 15;
	localparam int IDX_W         = 2 * TDIM_W + 1;
	localparam int DCOL_W        = 15;
	localparam int CNT_W         = 16;
	localparam int Q_DEPTH       = 2;
	localparam int Q_AW          = 1;

	localparam logic [15:0] OPAQUE_BIT  = 16'h8000;
	localparam logic [15:0] COLOR_MASK  = 16'h7fff;
	localparam logic [CNT_W-1:0] CLEAR_COUNT =
		(MAX_PIXELS > 65535) ? {CNT_W{1'b1}} : CNT_W'(MAX_PIXELS);

	localparam logic [3:0] OPC_CLEAR  = 4'd0;
	localparam logic [3:0] OPC_SET    = 4'd1;
	localparam logic [3:0] OPC_ON     = 4'd2;
	localparam logic [3:0] OPC_OFF    = 4'd3;
	localparam logic [3:0] OPC_PLOT   = 4'd4;
	localparam logic [3:0] OPC_HLINE  = 4'd5;
	localparam logic [3:0] OPC_VLINE  = 4'd6;
	localparam logic [3:0] OPC_RECT   = 4'd7;
	localparam logic [3:0] OPC_FILL   = 4'd8;
	localparam logic [3:0] OPC_SPRITE = 4'd9;
	localparam logic [3:0] OPC_PALW   = 4'd10;
	localparam logic [3:0] OPC_READ   = 4'd11;

	localparam logic [1:0] REG_TILE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_TILE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DRAW_COLOR  = 2'd2;

	typedef enum logic [3:0] {
		K_CLEAR, K_SET, K_ON, K_OFF, K_PLOT, K_HLINE, K_VLINE,
		K_RECT, K_FILL, K_SPRITE, K_PALW, K_READ, K_NOP
	} kind_t;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_START, ST_RMW, ST_SETUP, ST_RUN,
		ST_SPR_RD, ST_SPR_WR, ST_DONE
	} eng_state_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [11:0] pos_x;
		logic signed [11:0] pos_y;
		logic signed [11:0] span_w;
		logic signed [11:0] span_h;
		logic [15:0]        pixel_color;
		logic [31:0]        plane_bits;
		logic [3:0]         palette_number;
		logic [7:0]         palette_entry;
	} cmd_t;

	typedef struct packed {
		logic [TDIM_W-1:0] tile_width;
		logic [TDIM_W-1:0] tile_height;
		logic [DCOL_W-1:0] draw_color;
	} cfg_t;

	function automatic logic in_tile(input logic signed [CLP_W-1:0] x,
		input logic signed [CLP_W-1:0] y, input logic [TDIM_W-1:0] w,
		input logic [TDIM_W-1:0] h);
		logic signed [CLP_W-1:0] ws;
		logic signed [CLP_W-1:0] hs;
		ws = $signed(CLP_W'(w));
		hs = $signed(CLP_W'(h));
		return (x >= 0) && (y >= 0) && (x < ws) && (y < hs);
	endfunction

	function automatic logic [IDX_W-1:0] lin_idx(input logic [TDIM_W-1:0] x,
		input logic [TDIM_W-1:0] y, input logic [TDIM_W-1:0] w);
		return IDX_W'(y) * IDX_W'(w) + IDX_W'(x);
	endfunction

endpackage

@@ sv/tpde_front.sv @@
// Front end: accepts stream beats, decodes the opcode into a kind and
// queues commands for the back end. Depends on tpde_pkg.
module tpde_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [111:0]        s_tdata,   // pos_x, pos_y, span_w, span_h, pixel_color,
	                                       // plane_bits, palette_number, palette_entry, pad
	input  logic [3:0]          s_tuser,   // opcode
	input  logic                accept_en,
	output tpde_pkg::cmd_t      cmd,
	output logic                cmd_valid,
	input  logic                cmd_ready
);
	import tpde_pkg::*;

	cmd_t            q_mem [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_AW:0]   cnt_q;
	cmd_t            in_cmd;
	logic            push;
	logic            pop;

	always_comb begin
		case (s_tuser)
			OPC_CLEAR:  in_cmd.kind = K_CLEAR;
			OPC_SET:    in_cmd.kind = K_SET;
			OPC_ON:     in_cmd.kind = K_ON;
			OPC_OFF:    in_cmd.kind = K_OFF;
			OPC_PLOT:   in_cmd.kind = K_PLOT;
			OPC_HLINE:  in_cmd.kind = K_HLINE;
			OPC_VLINE:  in_cmd.kind = K_VLINE;
			OPC_RECT:   in_cmd.kind = K_RECT;
			OPC_FILL:   in_cmd.kind = K_FILL;
			OPC_SPRITE: in_cmd.kind = K_SPRITE;
			OPC_PALW:   in_cmd.kind = K_PALW;
			OPC_READ:   in_cmd.kind = K_READ;
			default:    in_cmd.kind = K_NOP;
		endcase
		in_cmd.pos_x          = s_tdata[11:0];
		in_cmd.pos_y          = s_tdata[23:12];
		in_cmd.span_w         = s_tdata[35:24];
		in_cmd.span_h         = s_tdata[47:36];
		in_cmd.pixel_color    = s_tdata[63:48];
		in_cmd.plane_bits     = s_tdata[95:64];
		in_cmd.palette_number = s_tdata[99:96];
		in_cmd.palette_entry  = s_tdata[107:100];
	end

	assign s_tready  = accept_en && (cnt_q != (Q_AW+1)'(Q_DEPTH));
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = q_mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) q_mem[wr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
		end
	end

endmodule

@@ sv/tpde_back.sv @@
// Back end: sequencer that carries out one command at a time against the
// pixel and palette memories and holds the result. Depends on tpde_pkg.
module tpde_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tpde_pkg::cfg_t   cfg,
	input  tpde_pkg::cmd_t   cmd,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	output logic             init_done,
	output logic             res_valid,
	input  logic             res_ready,
	output logic [15:0]      res_read_value,
	output logic [15:0]      res_pixels_written
);
	import tpde_pkg::*;

	logic [15:0] pix_mem [MAX_PIXELS];
	logic [15:0] pal_mem [PALETTE_WORDS];

	eng_state_t        state_q, state_d;
	cmd_t              cmd_q, cmd_d;
	logic              init_q, init_d;
	logic [PIX_AW-1:0] clr_q, clr_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
	logic [15:0]       rv_q, rv_d;
	logic [1:0]        seg_q, seg_d;
	logic [TDIM_W-1:0] row_q, row_d, row_end_q, row_end_d;
	logic              vert_q, vert_d;
	logic [TDIM_W-1:0] fix_q, fix_d, cur_q, cur_d, end_q, end_d;
	logic [2:0]        px_q, px_d;
	logic [PIX_AW-1:0] idx_q, idx_d;
	logic              res_valid_q;
	logic [15:0]       res_rv_q, res_cnt_q;
	logic              res_load;

	logic              pm_we, pm_re, pal_we, pal_re;
	logic [PIX_AW-1:0] pm_wa, pm_ra;
	logic [15:0]       pm_wd, pm_rd_q;
	logic [PAL_AW-1:0] pal_wa, pal_ra;
	logic [15:0]       pal_wd, pal_rd_q;

	logic signed [CLP_W-1:0] x15, y15, w15, h15, wid_s, hgt_s;
	logic signed [CLP_W-1:0] chk_x;
	logic              chk_ok;
	logic [IDX_W-1:0]  chk_idx;
	logic              sd_vert;
	logic signed [CLP_W-1:0] sd_fix, sd_start, sd_len, sd_s, sd_e, lim_fix, lim_run;
	logic              sd_run;
	logic [TDIM_W-1:0] run_x, run_y;
	logic [IDX_W-1:0]  run_idx;
	logic [3:0]        spr_c;
	logic [PAL_AW:0]   pal_top;
	logic signed [CLP_W-1:0] fy0, fy1;
	eng_state_t        seg_next_st;
	logic [1:0]        seg_next_sel;
	logic [TDIM_W-1:0] seg_next_row;

	assign x15   = CLP_W'(cmd_q.pos_x);
	assign y15   = CLP_W'(cmd_q.pos_y);
	assign w15   = CLP_W'(cmd_q.span_w);
	assign h15   = CLP_W'(cmd_q.span_h);
	assign wid_s = $signed(CLP_W'(cfg.tile_width));
	assign hgt_s = $signed(CLP_W'(cfg.tile_height));

	assign cnt_inc = (cnt_q == {CNT_W{1'b1}}) ? cnt_q : cnt_q + 1'b1;

	// single pixel check, shared by pixel ops and sprite rows
	assign chk_x   = (state_q == ST_SPR_WR) ? x15 + $signed(CLP_W'(px_q)) : x15;
	assign chk_idx = lin_idx(chk_x[TDIM_W-1:0], y15[TDIM_W-1:0], cfg.tile_width);
	assign chk_ok  = in_tile(chk_x, y15, cfg.tile_width, cfg.tile_height) &&
		(chk_idx < IDX_W'(MAX_PIXELS));

	// segment descriptor for lines, rect sides and fill rows
	always_comb begin
		sd_vert  = 1'b0;
		sd_fix   = y15;
		sd_start = x15;
		sd_len   = w15;
		case (cmd_q.kind)
			K_VLINE: begin
				sd_vert = 1'b1; sd_fix = x15; sd_start = y15; sd_len = h15;
			end
			K_FILL: begin
				sd_fix = $signed(CLP_W'(row_q));
			end
			K_RECT: begin
				case (seg_q)
					2'd1: begin
						sd_fix   = CLP_W'(y15 + h15 - 1);
						sd_start = CLP_W'(x15 + 1);
						sd_len   = CLP_W'(w15 - 1);
					end
					2'd2: begin
						sd_vert  = 1'b1; sd_fix = x15;
						sd_start = CLP_W'(y15 + 1);
						sd_len   = CLP_W'(h15 - 1);
					end
					2'd3: begin
						sd_vert  = 1'b1;
						sd_fix   = CLP_W'(x15 + w15 - 1);
						sd_start = CLP_W'(y15 + 1);
						sd_len   = CLP_W'(h15 - 2);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		lim_fix = sd_vert ? wid_s : hgt_s;
		lim_run = sd_vert ? hgt_s : wid_s;
		sd_s    = (sd_start < 0) ? '0 : sd_start;
		sd_e    = sd_start + sd_len;
		if (sd_e > lim_run) sd_e = lim_run;
		sd_run  = (sd_len > 0) && (sd_fix >= 0) && (sd_fix < lim_fix) && (sd_s < sd_e);
	end

	// what follows once a segment ends or is skipped
	always_comb begin
		seg_next_st  = ST_DONE;
		seg_next_sel = seg_q;
		seg_next_row = row_q;
		case (cmd_q.kind)
			K_RECT: begin
				if (seg_q != 2'd3) begin
					seg_next_st  = ST_SETUP;
					seg_next_sel = seg_q + 1'b1;
				end
			end
			K_FILL: begin
				if (({1'b0, row_q} + 1'b1) < {1'b0, row_end_q}) begin
					seg_next_st  = ST_SETUP;
					seg_next_row = row_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign run_x   = vert_q ? fix_q : cur_q;
	assign run_y   = vert_q ? cur_q : fix_q;
	assign run_idx = lin_idx(run_x, run_y, cfg.tile_width);

	assign spr_c = {cmd_q.plane_bits[24 + 7 - px_q], cmd_q.plane_bits[16 + 7 - px_q],
		cmd_q.plane_bits[8 + 7 - px_q], cmd_q.plane_bits[7 - px_q]};
	assign pal_top = {1'b0, cmd_q.palette_number, 4'b0} + (PAL_AW+1)'(16);

	assign fy0 = (y15 < 0) ? '0 : y15;
	assign fy1 = ((y15 + h15) > hgt_s) ? hgt_s : (y15 + h15);

	always_comb begin
		state_d   = state_q;
		cmd_d     = cmd_q;
		init_d    = init_q;
		clr_d     = clr_q;
		cnt_d     = cnt_q;
		rv_d      = rv_q;
		seg_d     = seg_q;
		row_d     = row_q;
		row_end_d = row_end_q;
		vert_d    = vert_q;
		fix_d     = fix_q;
		cur_d     = cur_q;
		end_d     = end_q;
		px_d      = px_q;
		idx_d     = idx_q;
		res_load  = 1'b0;
		cmd_ready = 1'b0;
		pm_we  = 1'b0; pm_wa = chk_idx[PIX_AW-1:0]; pm_wd = '0;
		pm_re  = 1'b0; pm_ra = chk_idx[PIX_AW-1:0];
		pal_we = 1'b0; pal_wa = cmd_q.palette_entry; pal_wd = cmd_q.pixel_color;
		pal_re = 1'b0; pal_ra = PAL_AW'({cmd_q.palette_number, spr_c});
		case (state_q)
			ST_CLR: begin
				pm_we = 1'b1;
				pm_wa = clr_q;
				if (clr_q == PIX_AW'(MAX_PIXELS - 1)) begin
					if (init_q) begin
						init_d  = 1'b0;
						state_d = ST_IDLE;
					end else begin
						cnt_d   = CLEAR_COUNT;
						state_d = ST_DONE;
					end
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					cmd_d   = cmd;
					cnt_d   = '0;
					rv_d    = '0;
					seg_d   = '0;
					px_d    = '0;
					state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = ST_DONE;
				case (cmd_q.kind)
					K_CLEAR: begin
						clr_d   = '0;
						state_d = ST_CLR;
					end
					K_SET, K_PLOT: begin
						if (chk_ok) begin
							pm_we = 1'b1;
							pm_wd = (cmd_q.kind == K_SET) ? (cmd_q.pixel_color | OPAQUE_BIT)
								: {1'b1, cfg.draw_color};
							cnt_d = cnt_inc;
						end
					end
					K_ON, K_OFF, K_READ: begin
						if (chk_ok) begin
							pm_re   = 1'b1;
							idx_d   = chk_idx[PIX_AW-1:0];
							state_d = ST_RMW;
						end
					end
					K_HLINE, K_VLINE, K_RECT: state_d = ST_SETUP;
					K_FILL: begin
						if ((h15 > 0) && (fy0 < fy1)) begin
							row_d     = fy0[TDIM_W-1:0];
							row_end_d = fy1[TDIM_W-1:0];
							state_d   = ST_SETUP;
						end
					end
					K_SPRITE: begin
						if (pal_top <= (PAL_AW+1)'(PALETTE_WORDS)) state_d = ST_SPR_RD;
					end
					K_PALW: begin
						pal_we = ({1'b0, cmd_q.palette_entry} < (PAL_AW+1)'(PALETTE_WORDS));
					end
					default: ;
				endcase
			end
			ST_RMW: begin
				state_d = ST_DONE;
				pm_wa   = idx_q;
				case (cmd_q.kind)
					K_ON: begin
						pm_we = 1'b1; pm_wd = pm_rd_q | OPAQUE_BIT; cnt_d = cnt_inc;
					end
					K_OFF: begin
						pm_we = 1'b1; pm_wd = pm_rd_q & COLOR_MASK; cnt_d = cnt_inc;
					end
					default: rv_d = pm_rd_q;
				endcase
			end
			ST_SETUP: begin
				if (sd_run) begin
					vert_d  = sd_vert;
					fix_d   = sd_fix[TDIM_W-1:0];
					cur_d   = sd_s[TDIM_W-1:0];
					end_d   = sd_e[TDIM_W-1:0];
					state_d = ST_RUN;
				end else begin
					state_d = seg_next_st;
					seg_d   = seg_next_sel;
					row_d   = seg_next_row;
				end
			end
			ST_RUN: begin
				if (run_idx < IDX_W'(MAX_PIXELS)) begin
					pm_we = 1'b1;
					pm_wa = run_idx[PIX_AW-1:0];
					pm_wd = {1'b1, cfg.draw_color};
					cnt_d = cnt_inc;
				end
				if (({1'b0, cur_q} + 1'b1) == {1'b0, end_q}) begin
					state_d = seg_next_st;
					seg_d   = seg_next_sel;
					row_d   = seg_next_row;
				end else begin
					cur_d = cur_q + 1'b1;
				end
			end
			ST_SPR_RD: begin
				if (spr_c != '0) begin
					pal_re  = 1'b1;
					state_d = ST_SPR_WR;
				end else if (px_q == 3'd7) begin
					state_d = ST_DONE;
				end else begin
					px_d = px_q + 1'b1;
				end
			end
			ST_SPR_WR: begin
				if (chk_ok) begin
					pm_we = 1'b1;
					pm_wd = pal_rd_q | OPAQUE_BIT;
					cnt_d = cnt_inc;
				end
				if (px_q == 3'd7) begin
					state_d = ST_DONE;
				end else begin
					px_d    = px_q + 1'b1;
					state_d = ST_SPR_RD;
				end
			end
			ST_DONE: begin
				if (!res_valid_q || res_ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pm_we) pix_mem[pm_wa] <= pm_wd;
		if (pm_re) pm_rd_q <= pix_mem[pm_ra];
	end

	always_ff @(posedge clk) begin
		if (pal_we) pal_mem[pal_wa] <= pal_wd;
		if (pal_re) pal_rd_q <= pal_mem[pal_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			init_q      <= 1'b1;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			init_q  <= init_d;
			clr_q   <= clr_d;
			if (res_load) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q     <= cmd_d;
		cnt_q     <= cnt_d;
		rv_q      <= rv_d;
		seg_q     <= seg_d;
		row_q     <= row_d;
		row_end_q <= row_end_d;
		vert_q    <= vert_d;
		fix_q     <= fix_d;
		cur_q     <= cur_d;
		end_q     <= end_d;
		px_q      <= px_d;
		idx_q     <= idx_d;
		if (res_load) begin
			res_rv_q  <= rv_q;
			res_cnt_q <= cnt_q;
		end
	end

	assign init_done          = !init_q;
	assign res_valid          = res_valid_q;
	assign res_read_value     = res_rv_q;
	assign res_pixels_written = res_cnt_q;

endmodule

@@ sv/tile_pixel_draw_engine_top.sv @@
// Sequencing: each line, rect side or fill row passes a setup state and then covers one
// pixel per cycle; a drawn sprite pixel takes a palette read state and a write state,
// a transparent one only the read state; clear walks every pixel of the store.
// Throughput: one item at a time in the sequencer, set by its single pixel write port;
// a two-deep command queue and an output register let both sides stall on their own.
// Reset: arst_n clears control at once, then a pass over every pixel zeroes the pixel store
// with s_tready low; configuration writes are taken throughout.
module tile_pixel_draw_engine_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,   // pos_x, pos_y, span_w, span_h, pixel_color,
	                                // plane_bits, palette_number, palette_entry, zero pad
	input  logic [3:0]   s_tuser,   // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,   // read_value, pixels_written
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [14:0]  cfg_data
);
	import tpde_pkg::*;

	cfg_t  cfg_q;
	cmd_t  cmd;
	logic  cmd_valid;
	logic  cmd_ready;
	logic  init_done;
	logic [15:0] read_value;
	logic [15:0] pixels_written;

	// registers are to be written only while the engine is idle (the block does not enforce it), so take every beat
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tile_width  <= '0;
			cfg_q.tile_height <= '0;
			cfg_q.draw_color  <= COLOR_MASK[DCOL_W-1:0];
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TILE_WIDTH:  cfg_q.tile_width  <= cfg_data[TDIM_W-1:0];
				REG_TILE_HEIGHT: cfg_q.tile_height <= cfg_data[TDIM_W-1:0];
				REG_DRAW_COLOR:  cfg_q.draw_color  <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: accept and decode beats, queue commands
	tpde_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.accept_en (init_done),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	// back: run commands against the memories, hold the result beat
	tpde_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg_q),
		.cmd                (cmd),
		.cmd_valid          (cmd_valid),
		.cmd_ready          (cmd_ready),
		.init_done          (init_done),
		.res_valid          (m_tvalid),
		.res_ready          (m_tready),
		.res_read_value     (read_value),
		.res_pixels_written (pixels_written)
	);

	assign m_tdata = {pixels_written, read_value};

endmodule

@@ sv/tpde_checker.sv @@
// Port-level checks for the tile pixel draw engine, bound to the top level.
// Depends only on the top level's ports.
module tpde_port_checks (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [31:0]  m_tdata
);
	logic [2:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= '0;
		else pend_q <= pend_q + 3'(s_tvalid && s_tready) - 3'(m_tvalid && m_tready);
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat dropped or changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 3'd0)
		else $error("result beat without an accepted item");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("more items in flight than queue, engine and output hold");

	a_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[15:0] != 16'd0) |-> m_tdata[31:16] == 16'd0)
		else $error("read result also reports written pixels");

endmodule

bind tile_pixel_draw_engine_top tpde_port_checks u_tpde_checker (.*);
